// ===== src/dsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsc_pkg: shared constants and types for the diffusion stencil pipeline
// Fixed point widths, item layouts, register indexes and a saturating add.
// ----------------------------------------------------------------------------
package dsc_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int IN_W      = DATA_W - 1;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int DEN_W     = DATA_W;
    localparam int Q_W       = DATA_W;
    localparam int DIV_LAT   = Q_W + 1;
    localparam int CPE_W     = 7;
    localparam int SIDE_CNT  = 4;
    localparam int HR_CNT    = 6;
    localparam int TERM_CNT  = 2 * SIDE_CNT;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CPE_X   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CPE_Y   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_TOP     = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN    = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_DIM = CFG_IDX_W'(7);

    // side order, matches the edge mask bits
    localparam int SIDE_W = 0;
    localparam int SIDE_E = 1;
    localparam int SIDE_S = 2;
    localparam int SIDE_N = 3;

    // half-resistance slots: own x, own y, then one per neighbour side
    localparam int HR_SELF_X = 0;
    localparam int HR_SELF_Y = 1;
    localparam int HR_NBR    = 2;

    localparam logic [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [IN_W-1:0]     diff_self;
        logic [IN_W-1:0]     len_x_self;
        logic [IN_W-1:0]     len_y_self;
        logic [IN_W-1:0]     diff_east;
        logic [IN_W-1:0]     len_x_east;
        logic [IN_W-1:0]     diff_west;
        logic [IN_W-1:0]     len_x_west;
        logic [IN_W-1:0]     diff_north;
        logic [IN_W-1:0]     len_y_north;
        logic [IN_W-1:0]     diff_south;
        logic [IN_W-1:0]     len_y_south;
        logic [SIDE_CNT-1:0] edge_mask;
    } cell_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] coef_diag;
        logic signed [DATA_W-1:0] coef_west;
        logic signed [DATA_W-1:0] coef_east;
        logic signed [DATA_W-1:0] coef_south;
        logic signed [DATA_W-1:0] coef_north;
        logic                     saturated;
    } row_t;

    typedef struct packed {
        logic [HR_CNT-1:0][IN_W-1:0] diff;
        logic [SIDE_CNT-1:0]         edges;
    } a_side_t;

    typedef struct packed {
        logic [IN_W-1:0]     dx;
        logic [IN_W-1:0]     dy;
        logic [SIDE_CNT-1:0] edges;
        logic                sat;
    } b_side_t;

    typedef struct packed {
        logic [SIDE_CNT-1:0] used;
        logic [SIDE_CNT-1:0] robin;
        logic [SIDE_CNT-1:0] neg;
        logic                sat;
    } c_side_t;

    typedef struct packed {
        logic [TERM_CNT-1:0][DATA_W-1:0] terms;
        logic [DATA_W-1:0]               acc;
        logic                            sat;
    } sum_t;

    // two's complement add clamped to the signed range; MSB of result flags a clamp
    function automatic logic [DATA_W:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            sat_add = {1'b1, (s[DATA_W] ? VMIN : VMAX)};
        else
            sat_add = {1'b0, s[DATA_W-1:0]};
    endfunction

endpackage

// ===== src/dsc_div.sv =====
// ----------------------------------------------------------------------------
// dsc_div: pipelined restoring divider
// One quotient bit per stage after the first; the first stage flags a zero
// divisor or a quotient that does not fit in Q_W bits.
// ----------------------------------------------------------------------------
module dsc_div
    import dsc_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo,
    output logic             bad
);

    logic [DEN_W-1:0] den_reg  [DIV_LAT];
    logic [DEN_W-1:0] rem_reg  [DIV_LAT];
    logic [Q_W-1:0]   bits_reg [DIV_LAT];   // numerator bits out, quotient bits in
    logic             bad_reg  [DIV_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]  <= den;
            rem_reg[0]  <= DEN_W'(num[NUM_W-1:Q_W]);
            bits_reg[0] <= num[Q_W-1:0];
            bad_reg[0]  <= (den == '0) || (DEN_W'(num[NUM_W-1:Q_W]) >= den);
        end
    end

    for (genvar k = 1; k < DIV_LAT; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        assign trial = {rem_reg[k-1], bits_reg[k-1][Q_W-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};
        assign ge    = !diff[DEN_W];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k]  <= den_reg[k-1];
                rem_reg[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                bits_reg[k] <= {bits_reg[k-1][Q_W-2:0], ge};
                bad_reg[k]  <= bad_reg[k-1];
            end
        end
    end

    assign quo = bits_reg[DIV_LAT-1];
    assign bad = bad_reg[DIV_LAT-1];

endmodule

// ===== src/diffusion_stencil_coefficients_top.sv =====
// ----------------------------------------------------------------------------
// diffusion_stencil_coefficients_top: five-point diffusion stencil row
// Turns one fine mesh cell into its diagonal and four neighbour entries.
// ----------------------------------------------------------------------------
// Usage:
//   mesh_cell / cell_valid / cell_stall carry one cell item in; row / row_valid /
//   row_stall carry one stencil row item out, one row per cell, in order.
//   The wr_en / wr_index / wr_data port sets the cell counts, boundary
//   ratios, open side mask and 1-D mode; write it only while the pipe is empty.
//   Stages in order: cell sizes (33-stage divider), half resistances (divider),
//   denominator set-up, couplings and boundary terms (divider), term select,
//   eight saturating adds for the diagonal, output register.
//   Throughput is one item per cycle unless the output stalls; the bit-serial
//   divider stages set the depth, and every stage takes a new item each cycle.
//   A stalled output freezes the whole pipe, so cell_stall follows row_stall
//   while a row is held. Reset empties the pipe and loads cell counts of one,
//   zero ratios, no open sides and 2-D mode.
// ----------------------------------------------------------------------------
module diffusion_stencil_coefficients_top
    import dsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [DATA_W-1:0]    wr_data,
    input  logic                 cell_valid,
    output logic                 cell_stall,
    input  cell_t                mesh_cell,
    output logic                 row_valid,
    input  logic                 row_stall,
    output row_t                 row
);

    // configuration
    logic [CPE_W-1:0]    cpe_x_reg;
    logic [CPE_W-1:0]    cpe_y_reg;
    logic [DATA_W-1:0]   ratio_reg [SIDE_CNT];
    logic [SIDE_CNT-1:0] open_reg;
    logic                one_dim_reg;

    logic [CPE_W-1:0]    cx_eff;
    logic [CPE_W-1:0]    cy_eff;
    logic                vert;
    logic                en;

    // size stage
    logic [NUM_W-1:0]    a_num [HR_CNT];
    logic [DEN_W-1:0]    a_den [HR_CNT];
    logic [Q_W-1:0]      a_quo [HR_CNT];
    logic [HR_CNT-1:0]   a_bad;
    a_side_t             a_in;
    a_side_t             a_side_reg [DIV_LAT];
    a_side_t             a_last;
    logic [DIV_LAT-1:0]  a_vld_reg;

    // half resistance stage
    logic [NUM_W-1:0]    b_num [HR_CNT];
    logic [DEN_W-1:0]    b_den [HR_CNT];
    logic [Q_W-1:0]      b_quo [HR_CNT];
    logic [HR_CNT-1:0]   b_bad;
    b_side_t             b_in;
    b_side_t             b_side_reg [DIV_LAT];
    b_side_t             b_last;
    logic [DIV_LAT-1:0]  b_vld_reg;

    logic [IN_W-1:0]     r_val [HR_CNT];
    logic [HR_CNT-1:0]   r_sat;
    logic [HR_CNT-1:0]   r_used;

    // denominator set-up
    logic [DEN_W-1:0]    p_den [SIDE_CNT];
    c_side_t             p_ctl;
    logic [DEN_W-1:0]    p_den_reg [SIDE_CNT];
    c_side_t             p_ctl_reg;
    logic [IN_W-1:0]     p_dx_reg;
    logic [IN_W-1:0]     p_dy_reg;
    logic                p_vld_reg;

    // coupling / boundary stage
    logic [NUM_W-1:0]    c_num [SIDE_CNT];
    logic [Q_W-1:0]      c_quo [SIDE_CNT];
    logic [SIDE_CNT-1:0] c_bad;
    c_side_t             c_side_reg [DIV_LAT];
    c_side_t             c_last;
    logic [DIV_LAT-1:0]  c_vld_reg;

    // diagonal sum
    sum_t                s_in;
    sum_t                sum_reg [TERM_CNT+1];
    logic [TERM_CNT:0]   sum_vld_reg;

    row_t                row_reg;
    logic                row_valid_reg;

    assign en         = !(row_valid_reg && row_stall);
    assign cell_stall = !en;
    assign row_valid  = row_valid_reg;
    assign row        = row_reg;

    assign cx_eff = (cpe_x_reg == '0) ? CPE_W'(1) : cpe_x_reg;
    assign cy_eff = (cpe_y_reg == '0) ? CPE_W'(1) : cpe_y_reg;
    assign vert   = !one_dim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpe_x_reg   <= CPE_W'(1);
            cpe_y_reg   <= CPE_W'(1);
            for (int j = 0; j < SIDE_CNT; j++)
                ratio_reg[j] <= '0;
            open_reg    <= '0;
            one_dim_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_CPE_X:   cpe_x_reg <= wr_data[CPE_W-1:0];
                CFG_CPE_Y:   cpe_y_reg <= wr_data[CPE_W-1:0];
                CFG_LEFT:    ratio_reg[SIDE_W] <= wr_data;
                CFG_RIGHT:   ratio_reg[SIDE_E] <= wr_data;
                CFG_BOTTOM:  ratio_reg[SIDE_S] <= wr_data;
                CFG_TOP:     ratio_reg[SIDE_N] <= wr_data;
                CFG_OPEN:    open_reg <= wr_data[SIDE_CNT-1:0];
                CFG_ONE_DIM: one_dim_reg <= wr_data[0];
                default:     ;
            endcase
        end
    end

    // ---- cell sizes: own dx, dy and the neighbours' along the coupling axis
    always_comb
    begin
        a_num[HR_SELF_X]        = NUM_W'(mesh_cell.len_x_self);
        a_den[HR_SELF_X]        = DEN_W'(cx_eff);
        a_num[HR_SELF_Y]        = NUM_W'(mesh_cell.len_y_self);
        a_den[HR_SELF_Y]        = DEN_W'(cy_eff);
        a_num[HR_NBR + SIDE_W]  = NUM_W'(mesh_cell.len_x_west);
        a_den[HR_NBR + SIDE_W]  = DEN_W'(cx_eff);
        a_num[HR_NBR + SIDE_E]  = NUM_W'(mesh_cell.len_x_east);
        a_den[HR_NBR + SIDE_E]  = DEN_W'(cx_eff);
        a_num[HR_NBR + SIDE_S]  = NUM_W'(mesh_cell.len_y_south);
        a_den[HR_NBR + SIDE_S]  = DEN_W'(cy_eff);
        a_num[HR_NBR + SIDE_N]  = NUM_W'(mesh_cell.len_y_north);
        a_den[HR_NBR + SIDE_N]  = DEN_W'(cy_eff);

        a_in.diff[HR_SELF_X]       = mesh_cell.diff_self;
        a_in.diff[HR_SELF_Y]       = mesh_cell.diff_self;
        a_in.diff[HR_NBR + SIDE_W] = mesh_cell.diff_west;
        a_in.diff[HR_NBR + SIDE_E] = mesh_cell.diff_east;
        a_in.diff[HR_NBR + SIDE_S] = mesh_cell.diff_south;
        a_in.diff[HR_NBR + SIDE_N] = mesh_cell.diff_north;
        a_in.edges                 = mesh_cell.edge_mask;
    end

    for (genvar k = 0; k < HR_CNT; k++)
    begin : g_size
        dsc_div u_div (
            .clk (clk),
            .en  (en),
            .num (a_num[k]),
            .den (a_den[k]),
            .quo (a_quo[k]),
            .bad (a_bad[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg[0] <= a_in;
            for (int k = 1; k < DIV_LAT; k++)
                a_side_reg[k] <= a_side_reg[k-1];
        end
    end

    assign a_last = a_side_reg[DIV_LAT-1];

    // ---- half resistances: size / (2 D)
    always_comb
    begin
        for (int k = 0; k < HR_CNT; k++)
        begin
            b_num[k] = NUM_W'({a_quo[k][IN_W-1:0], FRAC_BITS'(0)});
            b_den[k] = {a_last.diff[k], 1'b0};
        end
        b_in.dx    = a_quo[HR_SELF_X][IN_W-1:0];
        b_in.dy    = a_quo[HR_SELF_Y][IN_W-1:0];
        b_in.edges = a_last.edges;
        b_in.sat   = |a_bad;
    end

    for (genvar k = 0; k < HR_CNT; k++)
    begin : g_half
        dsc_div u_div (
            .clk (clk),
            .en  (en),
            .num (b_num[k]),
            .den (b_den[k]),
            .quo (b_quo[k]),
            .bad (b_bad[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_side_reg[0] <= b_in;
            for (int k = 1; k < DIV_LAT; k++)
                b_side_reg[k] <= b_side_reg[k-1];
        end
    end

    assign b_last = b_side_reg[DIV_LAT-1];

    // ---- clamp resistances, build each side's divisor
    always_comb
    begin
        for (int k = 0; k < HR_CNT; k++)
        begin
            r_sat[k] = b_bad[k] || b_quo[k][Q_W-1];
            r_val[k] = r_sat[k] ? VMAX[IN_W-1:0] : b_quo[k][IN_W-1:0];
        end
        r_used[HR_SELF_X]       = 1'b1;
        r_used[HR_SELF_Y]       = vert;
        r_used[HR_NBR + SIDE_W] = !b_last.edges[SIDE_W];
        r_used[HR_NBR + SIDE_E] = !b_last.edges[SIDE_E];
        r_used[HR_NBR + SIDE_S] = vert && !b_last.edges[SIDE_S];
        r_used[HR_NBR + SIDE_N] = vert && !b_last.edges[SIDE_N];
    end

    always_comb
    begin
        logic              side_vert;
        logic [IN_W-1:0]   rs;
        logic [IN_W-1:0]   rn;
        logic [DATA_W-1:0] v;
        logic [DEN_W-1:0]  m;
        logic [DEN_W-1:0]  pos_mag;
        logic [DEN_W:0]    sub;

        p_ctl.sat = b_last.sat || (|(r_sat & r_used));
        for (int j = 0; j < SIDE_CNT; j++)
        begin
            side_vert = (j == SIDE_S) || (j == SIDE_N);
            rs        = side_vert ? r_val[HR_SELF_Y] : r_val[HR_SELF_X];
            rn        = r_val[HR_NBR + j];
            v         = ratio_reg[j];
            m         = DEN_W'(0) - DEN_W'(v);
            pos_mag   = DEN_W'(rs) + DEN_W'(v[DATA_W-2:0]);
            sub       = {1'b0, DEN_W'(rs)} - {1'b0, m};

            p_ctl.robin[j] = b_last.edges[j];
            p_ctl.used[j]  = (!side_vert || vert) && (!b_last.edges[j] || open_reg[j]);
            // negative ratio larger than the resistance flips the term's sign
            p_ctl.neg[j]   = b_last.edges[j] && v[DATA_W-1] && sub[DEN_W];

            if (!b_last.edges[j])
                p_den[j] = DEN_W'(rs) + DEN_W'(rn);
            else if (!v[DATA_W-1])
                p_den[j] = pos_mag;
            else if (sub[DEN_W])
                p_den[j] = m - DEN_W'(rs);
            else
                p_den[j] = sub[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < SIDE_CNT; j++)
                p_den_reg[j] <= p_den[j];
            p_ctl_reg <= p_ctl;
            p_dx_reg  <= b_last.dx;
            p_dy_reg  <= b_last.dy;
        end
    end

    // ---- couplings and boundary terms
    always_comb
    begin
        c_num[SIDE_W] = NUM_W'({p_dy_reg, FRAC_BITS'(0)});
        c_num[SIDE_E] = NUM_W'({p_dy_reg, FRAC_BITS'(0)});
        c_num[SIDE_S] = NUM_W'({p_dx_reg, FRAC_BITS'(0)});
        c_num[SIDE_N] = NUM_W'({p_dx_reg, FRAC_BITS'(0)});
    end

    for (genvar j = 0; j < SIDE_CNT; j++)
    begin : g_side
        dsc_div u_div (
            .clk (clk),
            .en  (en),
            .num (c_num[j]),
            .den (p_den_reg[j]),
            .quo (c_quo[j]),
            .bad (c_bad[j])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg[0] <= p_ctl_reg;
            for (int k = 1; k < DIV_LAT; k++)
                c_side_reg[k] <= c_side_reg[k-1];
        end
    end

    assign c_last = c_side_reg[DIV_LAT-1];

    // ---- clamp quotients and sort them into boundary and coupling terms
    always_comb
    begin
        logic [Q_W-1:0]    q;
        logic              t_sat;
        logic [DATA_W-1:0] t_val;
        logic              sat_any;

        sat_any = 1'b0;
        for (int j = 0; j < SIDE_CNT; j++)
        begin
            q = c_quo[j];
            if (c_last.neg[j])
            begin
                // exactly the minimum is representable, anything larger clamps
                t_sat = c_bad[j] || (q[Q_W-1] && (q[Q_W-2:0] != '0));
                t_val = (c_bad[j] || q[Q_W-1]) ? VMIN : DATA_W'(0) - q;
            end
            else
            begin
                t_sat = c_bad[j] || q[Q_W-1];
                t_val = t_sat ? VMAX : q;
            end
            s_in.terms[j]            = (c_last.used[j] && c_last.robin[j]) ? t_val : '0;
            s_in.terms[SIDE_CNT + j] = (c_last.used[j] && !c_last.robin[j]) ? t_val : '0;
            sat_any = sat_any || (c_last.used[j] && t_sat);
        end
        s_in.acc = '0;
        s_in.sat = c_last.sat || sat_any;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sum_reg[0] <= s_in;
    end

    // boundary terms first, then couplings, one clamped add per stage
    for (genvar i = 1; i <= TERM_CNT; i++)
    begin : g_sum
        logic [DATA_W:0] total;

        assign total = sat_add(sum_reg[i-1].acc, sum_reg[i-1].terms[i-1]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sum_reg[i].terms <= sum_reg[i-1].terms;
                sum_reg[i].acc   <= total[DATA_W-1:0];
                sum_reg[i].sat   <= sum_reg[i-1].sat || total[DATA_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg.coef_diag  <= sum_reg[TERM_CNT].acc;
            row_reg.coef_west  <= DATA_W'(0) - sum_reg[TERM_CNT].terms[SIDE_CNT + SIDE_W];
            row_reg.coef_east  <= DATA_W'(0) - sum_reg[TERM_CNT].terms[SIDE_CNT + SIDE_E];
            row_reg.coef_south <= DATA_W'(0) - sum_reg[TERM_CNT].terms[SIDE_CNT + SIDE_S];
            row_reg.coef_north <= DATA_W'(0) - sum_reg[TERM_CNT].terms[SIDE_CNT + SIDE_N];
            row_reg.saturated  <= sum_reg[TERM_CNT].sat;
        end
    end

    // item valid bits, one per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= '0;
            b_vld_reg     <= '0;
            p_vld_reg     <= 1'b0;
            c_vld_reg     <= '0;
            sum_vld_reg   <= '0;
            row_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg     <= {a_vld_reg[DIV_LAT-2:0], cell_valid};
            b_vld_reg     <= {b_vld_reg[DIV_LAT-2:0], a_vld_reg[DIV_LAT-1]};
            p_vld_reg     <= b_vld_reg[DIV_LAT-1];
            c_vld_reg     <= {c_vld_reg[DIV_LAT-2:0], p_vld_reg};
            sum_vld_reg   <= {sum_vld_reg[TERM_CNT-1:0], c_vld_reg[DIV_LAT-1]};
            row_valid_reg <= sum_vld_reg[TERM_CNT];
        end
    end

    // a held row freezes every stage
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid_reg && row_stall |=>
            $stable(a_vld_reg) && $stable(b_vld_reg) && $stable(c_vld_reg)
            && $stable(sum_vld_reg))
        else $error("pipeline moved while the output was stalled");

    // cell counts are forced to at least one, so the size dividers never clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        a_vld_reg[DIV_LAT-1] |-> (a_bad == '0))
        else $error("cell size division flagged a bad divisor");

    // neighbour entries are minus a non-negative coupling
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid_reg |->
            (row_reg.coef_west[DATA_W-1] || (row_reg.coef_west == '0))
            && (row_reg.coef_east[DATA_W-1] || (row_reg.coef_east == '0))
            && (row_reg.coef_south[DATA_W-1] || (row_reg.coef_south == '0))
            && (row_reg.coef_north[DATA_W-1] || (row_reg.coef_north == '0)))
        else $error("positive neighbour entry");

endmodule

// ===== verif/stencil_row_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stencil_row_checker: scoreboard for the five-point stencil block
// Tracks register writes, predicts one stencil row per accepted cell item and
// compares each accepted row item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module stencil_row_checker
    import dsc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [CFG_IDX_W-1:0]         wr_index,
    input  logic [DATA_W-1:0]            wr_data,
    input  logic                         cell_valid,
    input  logic                         cell_stall,
    input  cell_t                        mesh_cell,
    input  logic                         row_valid,
    input  logic                         row_stall,
    input  row_t                         row,
    output int                           fails,
    output int                           pending
);

    localparam longint unsigned MAXV = 64'h7FFF_FFFF;
    localparam longint          MINV = -64'sh8000_0000;
    localparam int              FB   = FRAC_BITS;

    logic [6:0]  cpe_x, cpe_y;
    logic [31:0] ratio_l, ratio_r, ratio_b, ratio_t;
    logic [3:0]  open_sides;
    logic        one_dim;

    row_t rows_due[$];

    function automatic longint unsigned div_clamp(longint unsigned n, longint unsigned d,
                                                  longint unsigned lim, inout bit sat);
        longint unsigned q;
        if (d == 0)
        begin
            sat = 1'b1;
            return lim;
        end
        q = n / d;
        if (q > lim)
        begin
            sat = 1'b1;
            return lim;
        end
        return q;
    endfunction

    function automatic longint unsigned cell_size(longint unsigned len, logic [6:0] cnt);
        return len / ((cnt == 0) ? 64'd1 : longint'(cnt));
    endfunction

    function automatic longint unsigned half_res(longint unsigned d, longint unsigned diff,
                                                 inout bit sat);
        return div_clamp(d << FB, 2 * diff, MAXV, sat);
    endfunction

    function automatic longint unsigned coupling(longint unsigned num, longint unsigned r1,
                                                 longint unsigned r2, inout bit sat);
        return div_clamp(num << FB, r1 + r2, MAXV, sat);
    endfunction

    // boundary term num / (r + ratio), ratio signed
    function automatic longint robin_term(longint unsigned num, longint unsigned r,
                                          logic [31:0] ratio, inout bit sat);
        longint unsigned mag, m, q;
        bit neg;
        neg = 1'b0;
        if (!ratio[31])
            mag = r + longint'(ratio);
        else
        begin
            m = 64'h1_0000_0000 - longint'(ratio);
            if (r >= m)
                mag = r - m;
            else
            begin
                mag = m - r;
                neg = 1'b1;
            end
        end
        if (!neg)
            return longint'(div_clamp(num << FB, mag, MAXV, sat));
        q = div_clamp(num << FB, mag, MAXV + 1, sat);
        if (q == MAXV + 1)
            return MINV;
        return -longint'(q);
    endfunction

    function automatic longint add_clamp(longint a, longint b, inout bit sat);
        if (b > 0 && a > longint'(MAXV) - b)
        begin
            sat = 1'b1;
            return longint'(MAXV);
        end
        if (b < 0 && a < MINV - b)
        begin
            sat = 1'b1;
            return MINV;
        end
        return a + b;
    endfunction

    function automatic row_t predict_row(cell_t c);
        bit              sat;
        bit              vert;
        logic [3:0]      edges;
        longint unsigned dx, dy, rx, ry;
        longint          diag, w, e, s, n, t;
        row_t            r;
        sat   = 1'b0;
        edges = c.edge_mask;
        vert  = !one_dim;
        dx    = cell_size(c.len_x_self, cpe_x);
        dy    = cell_size(c.len_y_self, cpe_y);
        rx    = half_res(dx, c.diff_self, sat);
        ry    = 0;
        diag  = 0;
        w = 0; e = 0; s = 0; n = 0;
        if (vert)
            ry = half_res(dy, c.diff_self, sat);
        if (edges[0])
        begin
            if (open_sides[0])
                diag = add_clamp(diag, robin_term(dy, rx, ratio_l, sat), sat);
        end
        else
            w = longint'(coupling(dy, rx,
                half_res(cell_size(c.len_x_west, cpe_x), c.diff_west, sat), sat));
        if (edges[1])
        begin
            if (open_sides[1])
                diag = add_clamp(diag, robin_term(dy, rx, ratio_r, sat), sat);
        end
        else
            e = longint'(coupling(dy, rx,
                half_res(cell_size(c.len_x_east, cpe_x), c.diff_east, sat), sat));
        if (vert)
        begin
            if (edges[2])
            begin
                if (open_sides[2])
                    diag = add_clamp(diag, robin_term(dx, ry, ratio_b, sat), sat);
            end
            else
                s = longint'(coupling(dx, ry,
                    half_res(cell_size(c.len_y_south, cpe_y), c.diff_south, sat), sat));
            if (edges[3])
            begin
                if (open_sides[3])
                    diag = add_clamp(diag, robin_term(dx, ry, ratio_t, sat), sat);
            end
            else
                n = longint'(coupling(dx, ry,
                    half_res(cell_size(c.len_y_north, cpe_y), c.diff_north, sat), sat));
        end
        diag = add_clamp(diag, w, sat);
        diag = add_clamp(diag, e, sat);
        diag = add_clamp(diag, s, sat);
        diag = add_clamp(diag, n, sat);
        r.coef_diag  = diag[31:0];
        t = -w; r.coef_west  = t[31:0];
        t = -e; r.coef_east  = t[31:0];
        t = -s; r.coef_south = t[31:0];
        t = -n; r.coef_north = t[31:0];
        r.saturated  = sat;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        row_t due;
        if (!rst_n)
        begin
            cpe_x      <= 7'd1;
            cpe_y      <= 7'd1;
            ratio_l    <= '0;
            ratio_r    <= '0;
            ratio_b    <= '0;
            ratio_t    <= '0;
            open_sides <= '0;
            one_dim    <= 1'b0;
            fails      <= 0;
            pending    <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    CFG_CPE_X:   cpe_x      <= wr_data[6:0];
                    CFG_CPE_Y:   cpe_y      <= wr_data[6:0];
                    CFG_LEFT:    ratio_l    <= wr_data;
                    CFG_RIGHT:   ratio_r    <= wr_data;
                    CFG_BOTTOM:  ratio_b    <= wr_data;
                    CFG_TOP:     ratio_t    <= wr_data;
                    CFG_OPEN:    open_sides <= wr_data[3:0];
                    CFG_ONE_DIM: one_dim    <= wr_data[0];
                    default:     ;
                endcase
            end
            if (cell_valid && !cell_stall)
                rows_due.insert(rows_due.size(), predict_row(mesh_cell));
            if (row_valid && !row_stall)
            begin
                if (rows_due.size() == 0)
                begin
                    $error("row item with no cell outstanding");
                    fails <= fails + 1;
                end
                else
                begin
                    due = rows_due.pop_front();
                    if (row !== due)
                    begin
                        fails <= fails + 1;
                        if (row.coef_diag !== due.coef_diag)
                            $error("coef_diag exp %h got %h", due.coef_diag, row.coef_diag);
                        if (row.coef_west !== due.coef_west)
                            $error("coef_west exp %h got %h", due.coef_west, row.coef_west);
                        if (row.coef_east !== due.coef_east)
                            $error("coef_east exp %h got %h", due.coef_east, row.coef_east);
                        if (row.coef_south !== due.coef_south)
                            $error("coef_south exp %h got %h", due.coef_south,
                                   row.coef_south);
                        if (row.coef_north !== due.coef_north)
                            $error("coef_north exp %h got %h", due.coef_north,
                                   row.coef_north);
                        if (row.saturated !== due.saturated)
                            $error("saturated exp %b got %b", due.saturated, row.saturated);
                    end
                end
            end
            pending <= rows_due.size();
        end
    end

endmodule

// ===== verif/tb_diffusion_stencil_coefficients_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_diffusion_stencil_coefficients_top: stencil block testbench
// Drives directed and random cell items under a series of register settings,
// with random gaps and output stalls; the checker predicts and compares rows.
// ----------------------------------------------------------------------------
module tb_diffusion_stencil_coefficients_top
    import dsc_pkg::*;
;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN      = 130;
    localparam logic [30:0] ONES31 = 31'h7FFF_FFFF;

    logic           clk;
    logic           rst_n;
    logic           wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [DATA_W-1:0]    wr_data;
    logic           cell_valid;
    logic           cell_stall;
    cell_t          mesh_cell;
    logic           row_valid;
    logic           row_stall;
    row_t           row;
    int             fails;
    int             pending;
    int             idle_cycles;
    bit             hold_req;
    bit             calm;

    diffusion_stencil_coefficients_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .mesh_cell  (mesh_cell),
        .row_valid  (row_valid),
        .row_stall  (row_stall),
        .row        (row)
    );

    stencil_row_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .mesh_cell  (mesh_cell),
        .row_valid  (row_valid),
        .row_stall  (row_stall),
        .row        (row),
        .fails      (fails),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly short, now and then long
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 0;
        if (k < 90)
            return $urandom_range(1, 3);
        if (k < 98)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if ((cell_valid && !cell_stall) || (row_valid && !row_stall) || wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int cnt;
        row_stall = 1'b0;
        cnt = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                row_stall <= 1'b1;
                repeat (HOLD_LEN) @(negedge clk);
                row_stall <= 1'b0;
            end
            else if (cnt > 0)
            begin
                row_stall <= 1'b1;
                cnt--;
            end
            else
            begin
                row_stall <= 1'b0;
                cnt = calm ? 0 : pick_gap();
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    task automatic send_cell(cell_t c, int gap);
        @(negedge clk);
        cell_valid <= 1'b1;
        mesh_cell  <= c;
        do
            @(posedge clk);
        while (cell_stall);
        if (gap > 0)
        begin
            @(negedge clk);
            cell_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain_rows();
        @(negedge clk);
        cell_valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic set_all(logic [6:0] cx, logic [6:0] cy, logic [31:0] rl,
                           logic [31:0] rr, logic [31:0] rb, logic [31:0] rt,
                           logic [3:0] open_mask, logic one_d);
        write_reg(CFG_CPE_X, DATA_W'(cx));
        write_reg(CFG_CPE_Y, DATA_W'(cy));
        write_reg(CFG_LEFT, rl);
        write_reg(CFG_RIGHT, rr);
        write_reg(CFG_BOTTOM, rb);
        write_reg(CFG_TOP, rt);
        write_reg(CFG_OPEN, DATA_W'(open_mask));
        write_reg(CFG_ONE_DIM, DATA_W'(one_d));
    endtask

    function automatic logic [30:0] rand_field(bit allow_zero);
        case ($urandom_range(0, 9))
            0:       return ONES31;
            1:       return allow_zero ? 31'd0 : 31'd1;
            2:       return 31'd1;
            3, 4, 5: return 31'($urandom_range(32'h1000, 32'h10_0000));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_ratio();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3, 4:
            begin
                // near minus a typical half resistance, so the sum crosses zero
                v = $urandom_range(0, 32'h4_0000);
                return -v;
            end
            5:       return $urandom_range(0, 32'h4_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [6:0] rand_count();
        case ($urandom_range(0, 7))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'($urandom_range(65, 127));
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic cell_t rand_cell();
        cell_t c;
        c.diff_self   = rand_field(1'b0);
        c.len_x_self  = rand_field(1'b0);
        c.len_y_self  = rand_field(1'b0);
        c.diff_east   = rand_field(1'b1);
        c.len_x_east  = rand_field(1'b1);
        c.diff_west   = rand_field(1'b1);
        c.len_x_west  = rand_field(1'b1);
        c.diff_north  = rand_field(1'b1);
        c.len_y_north = rand_field(1'b1);
        c.diff_south  = rand_field(1'b1);
        c.len_y_south = rand_field(1'b1);
        c.edge_mask   = 4'($urandom);
        return c;
    endfunction

    function automatic cell_t uniform_cell(logic [30:0] self_v, logic [30:0] nbr_v,
                                           logic [3:0] edges);
        cell_t c;
        c.diff_self   = self_v;
        c.len_x_self  = self_v;
        c.len_y_self  = self_v;
        c.diff_east   = nbr_v;
        c.len_x_east  = nbr_v;
        c.diff_west   = nbr_v;
        c.len_x_west  = nbr_v;
        c.diff_north  = nbr_v;
        c.len_y_north = nbr_v;
        c.diff_south  = nbr_v;
        c.len_y_south = nbr_v;
        c.edge_mask   = edges;
        return c;
    endfunction

    task automatic directed_set();
        cell_t c;
        send_cell(uniform_cell(ONES31, ONES31, 4'h0), 0);
        send_cell(uniform_cell(31'd1, 31'd0, 4'h0), 1);
        send_cell(uniform_cell(31'h1_0000, 31'h1_0000, 4'h0), 0);
        send_cell(uniform_cell(31'h1_0000, 31'h1_0000, 4'hF), 2);
        send_cell(uniform_cell(31'h2_0000, 31'h8000, 4'h3), 0);
        send_cell(uniform_cell(31'h2_0000, 31'h8000, 4'hC), 0);
        send_cell(uniform_cell(ONES31, 31'd1, 4'h5), 0);
        send_cell(uniform_cell(31'd1, ONES31, 4'hA), 3);
        // neighbour with zero coefficient: zero divisor
        c = uniform_cell(31'h1_0000, 31'h1_0000, 4'h0);
        c.diff_east = '0;
        send_cell(c, 0);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        wr_en      = 1'b0;
        wr_index   = '0;
        wr_data    = '0;
        cell_valid = 1'b0;
        mesh_cell  = '0;
        hold_req   = 1'b0;
        calm       = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings
        directed_set();
        drain_rows();
        // zero counts, all sides open, small ratios (one positive, three negative), 1-D
        set_all(7'd0, 7'd0, -32'sh8000, -32'sh1_0000, 32'h4000, -32'sh2_0000,
                4'hF, 1'b1);
        directed_set();
        drain_rows();
        // counts of 64, extreme ratios, 2-D
        set_all(7'd64, 7'd64, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 4'hF, 1'b0);
        directed_set();
        drain_rows();

        for (int blk = 0; blk < 9; blk++)
        begin
            set_all(rand_count(), rand_count(), rand_ratio(), rand_ratio(), rand_ratio(),
                    rand_ratio(), 4'($urandom), ($urandom_range(0, 3) == 0));
            calm = (blk == 4);
            if (blk == 2)
                hold_req = 1'b1;
            for (int i = 0; i < 60; i++)
                send_cell(rand_cell(), calm ? 0 : pick_gap());
            drain_rows();
        end
        calm = 1'b0;

        repeat (DRAIN) @(posedge clk);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/dsc_pkg.sv
src/dsc_div.sv
src/diffusion_stencil_coefficients_top.sv
verif/stencil_row_checker.sv
verif/tb_diffusion_stencil_coefficients_top.sv
